### hdl/set_assoc_cache_lru_writeback_top_assert.svh
`ifndef SET_ASSOC_CACHE_LRU_WRITEBACK_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_WRITEBACK_TOP_ASSERT_SVH

// same-cycle implication
`define SACL_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sacl assertion failed");

// next-cycle implication
`define SACL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sacl assertion failed");

`endif

### hdl/sacl_pkg.sv
package sacl_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TAG_W      = 28;
  localparam int unsigned DIVIDEND_W = 30;
  localparam int unsigned DIVISOR_W  = 11;

  typedef struct packed {
    logic                  start;
    logic                  sel;
    logic [DIVIDEND_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } div_rsp_t;

endpackage

### hdl/sacl_req_if.sv
interface sacl_req_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [sacl_pkg::ADDR_W-1:0] address;
  logic [sacl_pkg::DATA_W-1:0] write_data;
  logic [sacl_pkg::DATA_W-1:0] fill_low_word;
  logic [sacl_pkg::DATA_W-1:0] fill_high_word;

  modport source (
    output valid, kind, address, write_data, fill_low_word, fill_high_word,
    input  ready
  );

  modport sink (
    input  valid, kind, address, write_data, fill_low_word, fill_high_word,
    output ready
  );
endinterface

### hdl/sacl_rsp_if.sv
interface sacl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sacl_pkg::DATA_W-1:0] read_data;
  logic                        miss;
  logic                        writeback_valid;
  logic [sacl_pkg::ADDR_W-1:0] writeback_address;
  logic [sacl_pkg::DATA_W-1:0] writeback_low_word;
  logic [sacl_pkg::DATA_W-1:0] writeback_high_word;

  modport source (
    output valid, read_data, miss, writeback_valid, writeback_address,
           writeback_low_word, writeback_high_word,
    input  ready
  );

  modport sink (
    input  valid, read_data, miss, writeback_valid, writeback_address,
           writeback_low_word, writeback_high_word,
    output ready
  );
endinterface

### hdl/set_assoc_cache_lru_writeback_top.sv
// Write-back, write-allocate set-associative data cache with LRU replacement
// (NUM_SETS sets, NUM_WAYS ways, WORDS_PER_BLOCK 32-bit words per block). Each
// request transaction is one read or write to a byte address and carries the
// memory words of its block, used only on a miss; each accepted request yields
// exactly one response transaction with the read word, the miss flag and any
// dirty-victim writeback. One request is processed at a time and ready is low
// meanwhile. The address is split by one shared reciprocal-multiply divider,
// used twice (by WORDS_PER_BLOCK, then by NUM_SETS); the metadata of the set
// is then read and the ways of the set are scanned one at a time through the
// tag RAM (stopping at a hit). Next the way is decided and the line address
// formed; a read hit then reads the word and a write hit writes it, while a
// miss writes the whole block, after first reading out a dirty victim. The
// metadata write follows, and the response is held until ready. After reset
// the metadata RAM is cleared, set by set, before the first request is taken.
`include "set_assoc_cache_lru_writeback_top_assert.svh"

module set_assoc_cache_lru_writeback_top #(
  parameter int unsigned NUM_SETS        = 2,
  parameter int unsigned NUM_WAYS        = 4,
  parameter int unsigned WORDS_PER_BLOCK = 2
) (
  input logic        clk_i,
  input logic        rst_ni,
  sacl_req_if.sink   req_i,
  sacl_rsp_if.source rsp_o
);

  localparam int unsigned DW        = sacl_pkg::DATA_W;
  localparam int unsigned TW        = sacl_pkg::TAG_W;
  localparam int unsigned NUM_LINES = NUM_SETS * NUM_WAYS;
  localparam int unsigned NUM_WORDS = NUM_LINES * WORDS_PER_BLOCK;
  localparam int unsigned SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned RW = WW;
  localparam int unsigned OW = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
  localparam int unsigned LW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned HI_OFF = (WORDS_PER_BLOCK > 1) ? 1 : 0;

  typedef struct packed {
    logic [NUM_WAYS-1:0]         valid;
    logic [NUM_WAYS-1:0]         dirty;
    logic [NUM_WAYS-1:0][RW-1:0] rank;
  } meta_t;

  localparam int unsigned MW = $bits(meta_t);

  typedef enum logic [20:0] {
    S_CLEAR   = 21'd1 << 0,
    S_IDLE    = 21'd1 << 1,
    S_DIVA    = 21'd1 << 2,
    S_DIVA_W  = 21'd1 << 3,
    S_DIVB    = 21'd1 << 4,
    S_DIVB_W  = 21'd1 << 5,
    S_META_RD = 21'd1 << 6,
    S_META_LD = 21'd1 << 7,
    S_TAG_RD  = 21'd1 << 8,
    S_TAG_CMP = 21'd1 << 9,
    S_DECIDE  = 21'd1 << 10,
    S_BASE    = 21'd1 << 11,
    S_WB_LO   = 21'd1 << 12,
    S_WB_HI   = 21'd1 << 13,
    S_WB_LD   = 21'd1 << 14,
    S_FILL    = 21'd1 << 15,
    S_HIT_RD  = 21'd1 << 16,
    S_HIT_LD  = 21'd1 << 17,
    S_HIT_WR  = 21'd1 << 18,
    S_META_WR = 21'd1 << 19,
    S_DONE    = 21'd1 << 20
  } state_e;

  state_e state_q, state_d;

  // request fields
  logic                             kind_q;
  logic [sacl_pkg::DIVIDEND_W-1:0]  wordno_q;
  logic [DW-1:0]                    wdata_q;
  logic [DW-1:0]                    flo_q;
  logic [DW-1:0]                    fhi_q;

  // address split
  logic [sacl_pkg::DIVIDEND_W-1:0]  blk_q;
  logic [OW-1:0]                    off_q;
  logic [TW-1:0]                    tag_q;
  logic [SW-1:0]                    set_q;

  // scan
  meta_t         meta_q;
  logic [WW-1:0] way_q;
  logic          hit_found_q;
  logic [WW-1:0] hit_way_q;
  logic          empty_found_q;
  logic [WW-1:0] empty_way_q;
  logic [RW-1:0] best_q;
  logic [WW-1:0] vict_way_q;
  logic [TW-1:0] vtag_q;
  logic [WW-1:0] way_sel;
  logic          way_last;
  logic          cmp_hit;

  // line update
  logic          miss_q;
  logic          wb_q;
  logic [LW-1:0] line_q;
  logic [AW-1:0] wbase_q;
  logic [DW-1:0] vblk_q;
  logic [OW-1:0] fcnt_q;
  logic [SW-1:0] clr_q;

  // response
  logic [DW-1:0] rdata_q;
  logic [DW-1:0] wb_addr_q;
  logic [DW-1:0] wb_lo_q;
  logic [DW-1:0] wb_hi_q;

  sacl_pkg::div_req_t div_req;
  sacl_pkg::div_rsp_t div_rsp;

  logic          meta_we;
  logic [SW-1:0] meta_waddr;
  meta_t         meta_wdata;
  meta_t         meta_new;
  logic [MW-1:0] meta_rdata;

  logic          tag_we;
  logic [LW-1:0] tag_raddr;
  logic [TW-1:0] tag_rdata;

  logic          word_we;
  logic [AW-1:0] word_waddr;
  logic [DW-1:0] word_wdata;
  logic [AW-1:0] word_raddr;
  logic [DW-1:0] word_rdata;

  function automatic logic [DW-1:0] fill_word(input logic [OW-1:0] offset,
                                               input logic [DW-1:0] lo,
                                               input logic [DW-1:0] hi);
    logic [DW-1:0] w;
    if (offset == OW'(0)) begin
      w = lo;
    end else if (32'(offset) == 32'd1) begin
      w = hi;
    end else begin
      w = '0;
    end
    return w;
  endfunction

  sacl_div #(.DIV_A(WORDS_PER_BLOCK), .DIV_B(NUM_SETS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sacl_ram #(.WIDTH(MW), .DEPTH(NUM_SETS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (set_q),
    .rdata_o (meta_rdata)
  );

  sacl_ram #(.WIDTH(TW), .DEPTH(NUM_LINES)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (line_q),
    .wdata_i (tag_q),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  sacl_ram #(.WIDTH(DW), .DEPTH(NUM_WORDS)) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (word_we),
    .waddr_i (word_waddr),
    .wdata_i (word_wdata),
    .raddr_i (word_raddr),
    .rdata_o (word_rdata)
  );

  assign div_req.start    = (state_q == S_DIVA) || (state_q == S_DIVB);
  assign div_req.sel      = (state_q == S_DIVB);
  assign div_req.dividend = (state_q == S_DIVA) ? wordno_q : blk_q;

  assign tag_raddr = LW'(32'(set_q) * NUM_WAYS + 32'(way_q));
  assign tag_we    = (state_q == S_META_WR);

  assign way_last = (way_q == WW'(NUM_WAYS - 1));
  assign cmp_hit  = meta_q.valid[way_q] && (tag_rdata == tag_q);
  assign way_sel  = hit_found_q ? hit_way_q : (empty_found_q ? empty_way_q : vict_way_q);

  always_comb begin
    meta_new = meta_q;
    for (int j = 0; j < NUM_WAYS; j++) begin
      if (WW'(j) == way_q) begin
        meta_new.valid[j] = 1'b1;
        meta_new.rank[j]  = '0;
        meta_new.dirty[j] = miss_q ? kind_q : (meta_q.dirty[j] | kind_q);
      end else if (meta_q.valid[j] && (miss_q || (meta_q.rank[j] < meta_q.rank[way_q]))) begin
        meta_new.rank[j] = meta_q.rank[j] + RW'(1);
      end
    end
  end

  assign meta_we    = (state_q == S_CLEAR) || (state_q == S_META_WR);
  assign meta_waddr = (state_q == S_CLEAR) ? clr_q : set_q;
  assign meta_wdata = (state_q == S_CLEAR) ? meta_t'('0) : meta_new;

  always_comb begin
    word_we    = (state_q == S_FILL) || (state_q == S_HIT_WR);
    word_waddr = AW'(32'(wbase_q) + 32'(off_q));
    word_wdata = wdata_q;
    if (state_q == S_FILL) begin
      word_waddr = AW'(32'(wbase_q) + 32'(fcnt_q));
      word_wdata = (kind_q && (fcnt_q == off_q)) ? wdata_q : fill_word(fcnt_q, flo_q, fhi_q);
    end
  end

  always_comb begin
    unique case (state_q)
      S_WB_LO: word_raddr = wbase_q;
      S_WB_HI: word_raddr = AW'(32'(wbase_q) + HI_OFF);
      default: word_raddr = AW'(32'(wbase_q) + 32'(off_q));
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:   if (clr_q == SW'(NUM_SETS - 1)) state_d = S_IDLE;
      S_IDLE:    if (req_i.valid) state_d = S_DIVA;
      S_DIVA:    state_d = S_DIVA_W;
      S_DIVA_W:  if (div_rsp.done) state_d = S_DIVB;
      S_DIVB:    state_d = S_DIVB_W;
      S_DIVB_W:  if (div_rsp.done) state_d = S_META_RD;
      S_META_RD: state_d = S_META_LD;
      S_META_LD: state_d = S_TAG_RD;
      S_TAG_RD:  state_d = S_TAG_CMP;
      S_TAG_CMP: state_d = (cmp_hit || way_last) ? S_DECIDE : S_TAG_RD;
      S_DECIDE:  state_d = S_BASE;
      S_BASE: begin
        if (wb_q) begin
          state_d = S_WB_LO;
        end else if (miss_q) begin
          state_d = S_FILL;
        end else if (kind_q) begin
          state_d = S_HIT_WR;
        end else begin
          state_d = S_HIT_RD;
        end
      end
      S_WB_LO:   state_d = S_WB_HI;
      S_WB_HI:   state_d = S_WB_LD;
      S_WB_LD:   state_d = S_FILL;
      S_FILL:    if (fcnt_q == OW'(WORDS_PER_BLOCK - 1)) state_d = S_META_WR;
      S_HIT_RD:  state_d = S_HIT_LD;
      S_HIT_LD:  state_d = S_META_WR;
      S_HIT_WR:  state_d = S_META_WR;
      S_META_WR: state_d = S_DONE;
      S_DONE:    if (rsp_o.ready) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      fcnt_q  <= '0;
      way_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + SW'(1);
      end
      if (state_q == S_FILL) begin
        fcnt_q <= fcnt_q + OW'(1);
      end else begin
        fcnt_q <= '0;
      end
      if (state_q == S_META_LD) begin
        way_q <= '0;
      end else if ((state_q == S_TAG_CMP) && !cmp_hit && !way_last) begin
        way_q <= way_q + WW'(1);
      end else if (state_q == S_DECIDE) begin
        way_q <= way_sel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        kind_q   <= req_i.kind;
        wordno_q <= req_i.address[sacl_pkg::ADDR_W-1:2];
        wdata_q  <= req_i.write_data;
        flo_q    <= req_i.fill_low_word;
        fhi_q    <= req_i.fill_high_word;
      end
      S_DIVA_W: begin
        blk_q <= div_rsp.quotient;
        off_q <= div_rsp.remainder[OW-1:0];
      end
      S_DIVB_W: begin
        tag_q <= div_rsp.quotient[TW-1:0];
        set_q <= div_rsp.remainder[SW-1:0];
      end
      S_META_LD: begin
        meta_q        <= meta_t'(meta_rdata);
        hit_found_q   <= 1'b0;
        empty_found_q <= 1'b0;
      end
      S_TAG_CMP: begin
        if (!hit_found_q && cmp_hit) begin
          hit_found_q <= 1'b1;
          hit_way_q   <= way_q;
        end
        if (!empty_found_q && !meta_q.valid[way_q]) begin
          empty_found_q <= 1'b1;
          empty_way_q   <= way_q;
        end
        if ((way_q == WW'(0)) || (meta_q.rank[way_q] > best_q)) begin
          best_q     <= meta_q.rank[way_q];
          vict_way_q <= way_q;
          vtag_q     <= tag_rdata;
        end
      end
      S_DECIDE: begin
        miss_q <= !hit_found_q;
        wb_q   <= !hit_found_q && !empty_found_q && meta_q.dirty[vict_way_q];
        line_q <= LW'(32'(set_q) * NUM_WAYS + 32'(way_sel));
      end
      S_BASE: begin
        wbase_q   <= AW'(32'(line_q) * WORDS_PER_BLOCK);
        vblk_q    <= 32'(32'(vtag_q) * NUM_SETS + 32'(set_q));
        rdata_q   <= (!kind_q && miss_q) ? fill_word(off_q, flo_q, fhi_q) : '0;
        wb_addr_q <= '0;
        wb_lo_q   <= '0;
        wb_hi_q   <= '0;
      end
      S_WB_LO: begin
        wb_addr_q <= {30'(vblk_q * WORDS_PER_BLOCK), 2'b00};
      end
      S_WB_HI: begin
        wb_lo_q <= word_rdata;
      end
      S_WB_LD: begin
        wb_hi_q <= (WORDS_PER_BLOCK > 1) ? word_rdata : '0;
      end
      S_HIT_LD: begin
        rdata_q <= word_rdata;
      end
      default: begin
      end
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);

  assign rsp_o.valid               = (state_q == S_DONE);
  assign rsp_o.read_data           = rdata_q;
  assign rsp_o.miss                = miss_q;
  assign rsp_o.writeback_valid     = wb_q;
  assign rsp_o.writeback_address   = wb_addr_q;
  assign rsp_o.writeback_low_word  = wb_lo_q;
  assign rsp_o.writeback_high_word = wb_hi_q;

  `SACL_ASSERT_IMPL(a_busy_while_rsp, clk_i, rst_ni, rsp_o.valid, !req_i.ready)
  `SACL_ASSERT_IMPL(a_wb_only_on_miss, clk_i, rst_ni, rsp_o.valid && rsp_o.writeback_valid, rsp_o.miss)
  `SACL_ASSERT_NEXT(a_accept_starts_split, clk_i, rst_ni, req_i.valid && req_i.ready, div_req.start)
  `SACL_ASSERT_IMPL(a_rsp_after_meta_wr, clk_i, rst_ni, $rose(rsp_o.valid), $past(meta_we))

endmodule

### hdl/sacl_ram.sv
module sacl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sacl_div.sv
module sacl_div #(
  parameter int unsigned DIV_A = 2,
  parameter int unsigned DIV_B = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sacl_pkg::div_req_t req_i,
  output sacl_pkg::div_rsp_t rsp_o
);

  localparam int unsigned QW  = sacl_pkg::DIVIDEND_W;
  localparam int unsigned RW  = sacl_pkg::DIVISOR_W;
  localparam int unsigned MW  = QW + 1;
  localparam int unsigned PW  = QW + MW;
  localparam int unsigned SHA = QW + $clog2(DIV_A);
  localparam int unsigned SHB = QW + $clog2(DIV_B);
  localparam logic [63:0] RECIP_A = ((64'd1 << SHA) + 64'(DIV_A) - 64'd1) / 64'(DIV_A);
  localparam logic [63:0] RECIP_B = ((64'd1 << SHB) + 64'(DIV_B) - 64'd1) / 64'(DIV_B);

  logic [QW-1:0] num_q;
  logic          sel_q;
  logic [QW-1:0] quo_q;
  logic [RW-1:0] rem_q;
  logic          mul_q;
  logic          sub_q;
  logic          done_q;

  logic [MW-1:0] recip;
  logic [RW-1:0] dvs;
  logic [PW-1:0] prod;
  logic [PW-1:0] shifted;
  logic [QW-1:0] back;

  // quotient by reciprocal multiplication, remainder by multiply-back and subtract
  assign recip   = sel_q ? RECIP_B[MW-1:0] : RECIP_A[MW-1:0];
  assign dvs     = sel_q ? RW'(DIV_B) : RW'(DIV_A);
  assign prod    = PW'(num_q) * PW'(recip);
  assign shifted = sel_q ? (prod >> SHB) : (prod >> SHA);
  assign back    = QW'(quo_q * QW'(dvs));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= req_i.start;
      sub_q  <= mul_q;
      done_q <= sub_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      sel_q <= req_i.sel;
    end
    if (mul_q) begin
      quo_q <= shifted[QW-1:0];
    end
    if (sub_q) begin
      rem_q <= RW'(num_q - back);
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule
